/* rtl/core/wuvc_pkg.sv */
// ----------------------------------------------------------------------------
// wuvc_pkg
// shared constants, register indexes, configuration struct and cordic table
// ----------------------------------------------------------------------------
package wuvc_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_MAX        = 24;
    localparam int BLEND_LAT         = 6;
    localparam int OUT_LAT           = 4;

    localparam logic [2:0] REG_GOAL_W  = 3'd0;
    localparam logic [2:0] REG_FORM_W  = 3'd1;
    localparam logic [2:0] REG_AVOID_W = 3'd2;
    localparam logic [2:0] REG_GAIN    = 3'd3;
    localparam logic [2:0] REG_INV_EPS = 3'd4;
    localparam logic [2:0] REG_THRESH  = 3'd5;
    localparam logic [2:0] REG_MAX_LIN = 3'd6;
    localparam logic [2:0] REG_MAX_ANG = 3'd7;

    localparam logic [1:0] MODE_LEADER   = 2'd0;
    localparam logic [1:0] MODE_FOLLOWER = 2'd1;
    localparam logic [1:0] MODE_CENTER   = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    localparam logic [13:0] K_SEVEN_TENTHS = 14'd11469;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    typedef struct packed {
        logic [15:0] goal_weight;
        logic [15:0] formation_weight;
        logic [15:0] avoid_weight;
        logic [15:0] overall_gain;
        logic [15:0] inv_epsilon;
        logic [31:0] norm_threshold;
        logic [14:0] max_linear;
        logic [14:0] max_angular;
    } t_cfg;

    function automatic logic [31:0] atan_turns(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
            12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
            18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
            21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/wuvc_blend.sv */
// ----------------------------------------------------------------------------
// wuvc_blend
// weighted blend of the three velocity vectors, gain, saturation and norm
// ----------------------------------------------------------------------------
module wuvc_blend (
    input  logic                i_clk,
    input  logic                i_en,
    input  wuvc_pkg::t_cfg      i_cfg,
    input  logic [1:0]          i_mode,
    input  logic signed [15:0]  i_goal_vx,
    input  logic signed [15:0]  i_goal_vy,
    input  logic signed [15:0]  i_form_vx,
    input  logic signed [15:0]  i_form_vy,
    input  logic signed [15:0]  i_avoid_vx,
    input  logic signed [15:0]  i_avoid_vy,
    output logic [1:0]          o_mode,
    output logic signed [15:0]  o_bx,
    output logic signed [15:0]  o_by,
    output logic                o_zero
);
    import wuvc_pkg::*;

    logic [1:0]         r_m1, r_m2, r_m3, r_m4, r_m5, r_m6;
    logic signed [32:0] r_gx, r_gy, r_fx, r_fy, r_ax, r_ay;
    logic signed [34:0] r_sx, r_sy;
    logic signed [51:0] r_tx, r_ty;
    logic signed [66:0] r_ux, r_uy;
    logic signed [15:0] r_bx5, r_by5, r_bx6, r_by6;
    logic [31:0]        r_qx, r_qy;
    logic signed [66:0] n_rx, n_ry;
    logic signed [15:0] n_bx, n_by;
    logic [32:0]        w_norm;

    logic signed [16:0] w_gw, w_fw, w_aw;

    // weights dropped for the vectors that a mode does not use
    assign w_gw = (i_mode == MODE_FOLLOWER) ? 17'sd0 : $signed({1'b0, i_cfg.goal_weight});
    assign w_fw = (i_mode == MODE_LEADER)   ? 17'sd0 : $signed({1'b0, i_cfg.formation_weight});
    assign w_aw = $signed({1'b0, i_cfg.avoid_weight});

    always_comb begin
        n_rx = (r_ux + (67'sd1 <<< 41)) >>> 42;
        n_ry = (r_uy + (67'sd1 <<< 41)) >>> 42;
        if (n_rx > 67'sd32767)       n_bx = 16'sd32767;
        else if (n_rx < -67'sd32768) n_bx = -16'sd32768;
        else                         n_bx = n_rx[15:0];
        if (n_ry > 67'sd32767)       n_by = 16'sd32767;
        else if (n_ry < -67'sd32768) n_by = -16'sd32768;
        else                         n_by = n_ry[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1 <= i_mode;
            r_gx <= 33'(i_goal_vx * w_gw);
            r_gy <= 33'(i_goal_vy * w_gw);
            r_fx <= 33'(i_form_vx * w_fw);
            r_fy <= 33'(i_form_vy * w_fw);
            r_ax <= 33'(i_avoid_vx * w_aw);
            r_ay <= 33'(i_avoid_vy * w_aw);

            r_m2 <= r_m1;
            r_sx <= 35'(r_gx) + 35'(r_fx) + 35'(r_ax);
            r_sy <= 35'(r_gy) + 35'(r_fy) + 35'(r_ay);

            r_m3 <= r_m2;
            r_tx <= 52'(r_sx * $signed({1'b0, i_cfg.overall_gain}));
            r_ty <= 52'(r_sy * $signed({1'b0, i_cfg.overall_gain}));

            // centre mode takes 0.7; others are aligned to the same scale
            r_m4 <= r_m3;
            if (r_m3 == MODE_CENTER) begin
                r_ux <= 67'(r_tx * $signed({1'b0, K_SEVEN_TENTHS}));
                r_uy <= 67'(r_ty * $signed({1'b0, K_SEVEN_TENTHS}));
            end else begin
                r_ux <= 67'(r_tx) <<< 14;
                r_uy <= 67'(r_ty) <<< 14;
            end

            r_m5  <= r_m4;
            r_bx5 <= n_bx;
            r_by5 <= n_by;

            r_m6  <= r_m5;
            r_bx6 <= r_bx5;
            r_by6 <= r_by5;
            r_qx  <= 32'(r_bx5 * r_bx5);
            r_qy  <= 32'(r_by5 * r_by5);
        end
    end

    assign w_norm = {1'b0, r_qx} + {1'b0, r_qy};
    assign o_mode = r_m6;
    assign o_bx   = r_bx6;
    assign o_by   = r_by6;
    assign o_zero = (r_m6 == MODE_UNUSED) || (w_norm < {1'b0, i_cfg.norm_threshold});

endmodule

/* rtl/core/wuvc_cordic.sv */
// ----------------------------------------------------------------------------
// wuvc_cordic
// pipelined rotation-mode cordic, one stage per iteration, cos and sin in q.30
// ----------------------------------------------------------------------------
module wuvc_cordic #(
    parameter int CORDIC_STAGES = wuvc_pkg::CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_yaw,
    output logic signed [32:0] o_cos,
    output logic signed [32:0] o_sin
);
    import wuvc_pkg::*;

    localparam int N = (CORDIC_STAGES < CORDIC_MAX) ? CORDIC_STAGES : CORDIC_MAX;

    logic signed [32:0] r_x [N+1];
    logic signed [32:0] r_y [N+1];
    logic signed [32:0] r_z [N+1];
    logic               r_flip [N+1];
    logic signed [32:0] w_z0;

    assign w_z0 = 33'($signed({i_yaw, 16'h0000}));

    // beyond a quarter turn, rotate by a half turn and negate at the end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_GAIN;
            r_y[0] <= 33'sd0;
            if (w_z0 > 33'sh040000000) begin
                r_z[0]    <= w_z0 - 33'sh080000000;
                r_flip[0] <= 1'b1;
            end else if (w_z0 < -33'sh040000000) begin
                r_z[0]    <= w_z0 + 33'sh080000000;
                r_flip[0] <= 1'b1;
            end else begin
                r_z[0]    <= w_z0;
                r_flip[0] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam logic signed [32:0] ATAN = $signed({1'b0, atan_turns(i)});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flip[i+1] <= r_flip[i];
                if (!r_z[i][32]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ATAN;
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ATAN;
                end
            end
        end
    end

    assign o_cos = r_flip[N] ? -r_x[N] : r_x[N];
    assign o_sin = r_flip[N] ? -r_y[N] : r_y[N];

endmodule

/* rtl/core/wuvc_out.sv */
// ----------------------------------------------------------------------------
// wuvc_out
// body-frame projection, 1/epsilon scaling, clamps and leader halving
// ----------------------------------------------------------------------------
module wuvc_out (
    input  logic               i_clk,
    input  logic               i_en,
    input  wuvc_pkg::t_cfg     i_cfg,
    input  logic [1:0]         i_mode,
    input  logic               i_zero,
    input  logic signed [15:0] i_bx,
    input  logic signed [15:0] i_by,
    input  logic signed [32:0] i_cos,
    input  logic signed [32:0] i_sin,
    output logic signed [15:0] o_linear_speed,
    output logic signed [15:0] o_angular_speed
);
    import wuvc_pkg::*;

    logic [1:0]         r_m1, r_m2, r_m3;
    logic               r_z1, r_z2, r_z3;
    logic signed [48:0] r_xc, r_ys, r_yc, r_xs;
    logic signed [49:0] r_ls, r_as;
    logic signed [66:0] r_ap;
    logic signed [20:0] r_lin;
    logic signed [15:0] r_lo, r_ao;
    logic signed [28:0] n_ang;
    logic signed [20:0] n_lc;
    logic signed [28:0] n_ac;
    logic signed [16:0] n_lh, n_ah;
    logic signed [20:0] w_ml;
    logic signed [28:0] w_ma;

    assign w_ml = $signed({6'd0, i_cfg.max_linear});
    assign w_ma = $signed({14'd0, i_cfg.max_angular});

    always_comb begin
        n_ang = 29'((r_ap + (67'sd1 <<< 37)) >>> 38);
        if (r_lin > w_ml)       n_lc = w_ml;
        else if (r_lin < -w_ml) n_lc = -w_ml;
        else                    n_lc = r_lin;
        if (n_ang > w_ma)       n_ac = w_ma;
        else if (n_ang < -w_ma) n_ac = -w_ma;
        else                    n_ac = n_ang;
        // leader halving rounds half up
        if (r_m3 == MODE_LEADER) begin
            n_lh = (17'(n_lc) + 17'sd1) >>> 1;
            n_ah = (17'(n_ac) + 17'sd1) >>> 1;
        end else begin
            n_lh = 17'(n_lc);
            n_ah = 17'(n_ac);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1 <= i_mode;
            r_z1 <= i_zero;
            r_xc <= 49'(i_bx * i_cos);
            r_ys <= 49'(i_by * i_sin);
            r_yc <= 49'(i_by * i_cos);
            r_xs <= 49'(i_bx * i_sin);

            r_m2 <= r_m1;
            r_z2 <= r_z1;
            r_ls <= 50'(r_xc) + 50'(r_ys);
            r_as <= 50'(r_yc) - 50'(r_xs);

            r_m3  <= r_m2;
            r_z3  <= r_z2;
            r_lin <= 21'((r_ls + (50'sd1 <<< 29)) >>> 30);
            r_ap  <= 67'(r_as * $signed({1'b0, i_cfg.inv_epsilon}));

            r_lo <= r_z3 ? 16'sd0 : n_lh[15:0];
            r_ao <= r_z3 ? 16'sd0 : n_ah[15:0];
        end
    end

    assign o_linear_speed  = r_lo;
    assign o_angular_speed = r_ao;

endmodule

/* rtl/core/weighted_unicycle_velocity_command.sv */
// ----------------------------------------------------------------------------
// weighted_unicycle_velocity_command
// blends goal, formation and avoidance velocities and turns the blend into a
// unicycle forward speed and turn rate through a pipelined cordic rotation
// ----------------------------------------------------------------------------
//  channel   signals                                    direction
//  request   i_valid, o_stall, i_mode .. i_yaw          in
//  result    o_valid, i_stall, o_linear_speed, o_angular in->out
//  config    i_cfg_we, i_cfg_idx, i_cfg_data            in, write only
//
//  one request enters every cycle unless a stalled result holds the pipeline;
//  a request passes through the cordic pipeline (pre-rotation plus one stage per
//  iteration) followed by the four output stages
//  reset clears the valid bits and loads the default register values
//  a stalled result freezes the whole pipeline, so nothing is lost or repeated
// ----------------------------------------------------------------------------
module weighted_unicycle_velocity_command #(
    parameter int CORDIC_STAGES = wuvc_pkg::CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_mode,
    input  logic signed [15:0] i_goal_vx,
    input  logic signed [15:0] i_goal_vy,
    input  logic signed [15:0] i_form_vx,
    input  logic signed [15:0] i_form_vy,
    input  logic signed [15:0] i_avoid_vx,
    input  logic signed [15:0] i_avoid_vy,
    input  logic signed [15:0] i_yaw,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_linear_speed,
    output logic signed [15:0] o_angular_speed,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    import wuvc_pkg::*;

    // cordic depth: pre-rotation register plus the iterations used
    localparam int CD  = ((CORDIC_STAGES < CORDIC_MAX) ? CORDIC_STAGES : CORDIC_MAX) + 1;
    // blend results wait this long to meet the cordic output
    localparam int DLY = CD - BLEND_LAT;
    localparam int LAT = CD + OUT_LAT;

    t_cfg r_cfg;
    logic [LAT-1:0] r_vld;
    logic w_en;

    logic [1:0]         w_bmode;
    logic signed [15:0] w_bx, w_by;
    logic               w_bzero;
    logic signed [32:0] w_cos, w_sin;

    logic [1:0]         r_dm [DLY];
    logic signed [15:0] r_dx [DLY];
    logic signed [15:0] r_dy [DLY];
    logic               r_dz [DLY];

    // global advance: only a held result stops the pipeline
    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.goal_weight      <= 16'd3277;
            r_cfg.formation_weight <= 16'd3277;
            r_cfg.avoid_weight     <= 16'd11469;
            r_cfg.overall_gain     <= 16'd30310;
            r_cfg.inv_epsilon      <= 16'd2560;
            r_cfg.norm_threshold   <= 32'd167772;
            r_cfg.max_linear       <= 15'd4096;
            r_cfg.max_angular      <= 15'd8192;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GOAL_W:  r_cfg.goal_weight      <= i_cfg_data[15:0];
                REG_FORM_W:  r_cfg.formation_weight <= i_cfg_data[15:0];
                REG_AVOID_W: r_cfg.avoid_weight     <= i_cfg_data[15:0];
                REG_GAIN:    r_cfg.overall_gain     <= i_cfg_data[15:0];
                REG_INV_EPS: r_cfg.inv_epsilon      <= i_cfg_data[15:0];
                REG_THRESH:  r_cfg.norm_threshold   <= i_cfg_data;
                REG_MAX_LIN: r_cfg.max_linear       <= i_cfg_data[14:0];
                REG_MAX_ANG: r_cfg.max_angular      <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    wuvc_blend u_blend (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_cfg      (r_cfg),
        .i_mode     (i_mode),
        .i_goal_vx  (i_goal_vx),
        .i_goal_vy  (i_goal_vy),
        .i_form_vx  (i_form_vx),
        .i_form_vy  (i_form_vy),
        .i_avoid_vx (i_avoid_vx),
        .i_avoid_vy (i_avoid_vy),
        .o_mode     (w_bmode),
        .o_bx       (w_bx),
        .o_by       (w_by),
        .o_zero     (w_bzero)
    );

    wuvc_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_yaw (i_yaw),
        .o_cos (w_cos),
        .o_sin (w_sin)
    );

    // alignment delay for the blend, the dead-zone flag and the mode
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dm[0] <= w_bmode;
            r_dx[0] <= w_bx;
            r_dy[0] <= w_by;
            r_dz[0] <= w_bzero;
            for (int k = 1; k < DLY; k++) begin
                r_dm[k] <= r_dm[k-1];
                r_dx[k] <= r_dx[k-1];
                r_dy[k] <= r_dy[k-1];
                r_dz[k] <= r_dz[k-1];
            end
        end
    end

    wuvc_out u_out (
        .i_clk           (i_clk),
        .i_en            (w_en),
        .i_cfg           (r_cfg),
        .i_mode          (r_dm[DLY-1]),
        .i_zero          (r_dz[DLY-1]),
        .i_bx            (r_dx[DLY-1]),
        .i_by            (r_dy[DLY-1]),
        .i_cos           (w_cos),
        .i_sin           (w_sin),
        .o_linear_speed  (o_linear_speed),
        .o_angular_speed (o_angular_speed)
    );

endmodule

/* bench/weighted_unicycle_velocity_command_test.sv */
// ----------------------------------------------------------------------------
// weighted_unicycle_velocity_command_test
// drives weighted velocity blend requests through the block, predicts each
// speed command from its own fixed-point model and compares them in order
// ----------------------------------------------------------------------------
module weighted_unicycle_velocity_command_test;
    import wuvc_pkg::*;

    localparam int STAGES    = CORDIC_STAGES_DEF;
    localparam int LATENCY   = STAGES + 5;
    localparam int MAX_CYCLE = 400000;

    typedef struct {
        logic [1:0]         mode;
        logic signed [15:0] gvx, gvy, fvx, fvy, avx, avy, yaw;
    } t_request;

    typedef struct {
        logic signed [15:0] lin;
        logic signed [15:0] ang;
    } t_command;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_mode = '0;
    logic signed [15:0] i_goal_vx = '0, i_goal_vy = '0, i_form_vx = '0, i_form_vy = '0;
    logic signed [15:0] i_avoid_vx = '0, i_avoid_vy = '0, i_yaw = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_linear_speed, o_angular_speed;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_data = '0;

    weighted_unicycle_velocity_command uut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor copy of the registers
    t_cfg     cfg;
    t_command pending_cmds[$];
    int       mismatches = 0;
    int       cycles = 0;
    int       requests_sent = 0;
    int       commands_seen = 0;
    int       idle_pct = 14;     // percent of idling on both sides
    bit       hold_off = 1'b0;   // long receiver stall in progress
    int       hold_len = 0;

    function automatic longint shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint round_shr(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp_mag(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // world-to-body rotation factors in q.30, sign-folded beyond a quarter turn
    function automatic void heading_cos_sin(input logic signed [15:0] yaw,
                                            output longint c, output longint s);
        longint z, x, y, t;
        bit     flip;
        z = longint'(yaw) <<< 16;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (z > 64'sh40000000) begin
            z -= 64'sh80000000; flip = 1'b1;
        end else if (z < -64'sh40000000) begin
            z += 64'sh80000000; flip = 1'b1;
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            if (z >= 0) begin
                t = x - shr(y, i); y = y + shr(x, i); x = t;
                z -= longint'(atan_turns(i));
            end else begin
                t = x + shr(y, i); y = y - shr(x, i); x = t;
                z += longint'(atan_turns(i));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic t_command velocity_command(t_request r);
        t_command cmd;
        longint   sx, sy, bx, by, c, s, lin, ang;
        longint   nrm;
        cmd.lin = '0;
        cmd.ang = '0;
        if (r.mode == MODE_UNUSED) return cmd;
        sx = longint'(r.avx) * longint'(cfg.avoid_weight);
        sy = longint'(r.avy) * longint'(cfg.avoid_weight);
        if (r.mode != MODE_FOLLOWER) begin
            sx += longint'(r.gvx) * longint'(cfg.goal_weight);
            sy += longint'(r.gvy) * longint'(cfg.goal_weight);
        end
        if (r.mode != MODE_LEADER) begin
            sx += longint'(r.fvx) * longint'(cfg.formation_weight);
            sy += longint'(r.fvy) * longint'(cfg.formation_weight);
        end
        sx *= longint'(cfg.overall_gain);
        sy *= longint'(cfg.overall_gain);
        if (r.mode == MODE_CENTER) begin
            bx = round_shr(sx * 11469, 42);
            by = round_shr(sy * 11469, 42);
        end else begin
            bx = round_shr(sx, 28);
            by = round_shr(sy, 28);
        end
        bx = sat16(bx);
        by = sat16(by);
        nrm = bx * bx + by * by;
        if (nrm < longint'(cfg.norm_threshold)) return cmd;
        heading_cos_sin(r.yaw, c, s);
        lin = round_shr(bx * c + by * s, 30);
        ang = round_shr((by * c - bx * s) * longint'(cfg.inv_epsilon), 38);
        lin = clamp_mag(clamp_mag(lin, longint'(cfg.max_linear)), 32767);
        ang = clamp_mag(clamp_mag(ang, longint'(cfg.max_angular)), 32767);
        if (r.mode == MODE_LEADER) begin
            lin = (lin + 1) >>> 1;
            ang = (ang + 1) >>> 1;
        end
        cmd.lin = lin[15:0];
        cmd.ang = ang[15:0];
        return cmd;
    endfunction

    // receiver side stall, with an occasional long hold-off
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (hold_off) begin
            i_stall <= 1'b1;
            if (hold_len > 0) hold_len <= hold_len - 1;
            else hold_off <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < idle_pct);
        end
        if (cycles > MAX_CYCLE) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_command want;
        if (i_rst_n && o_valid && !i_stall) begin
            commands_seen++;
            if (pending_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected command lin=%0d ang=%0d", o_linear_speed,
                             o_angular_speed);
            end else begin
                want = pending_cmds.pop_front();
                if (want.lin !== o_linear_speed || want.ang !== o_angular_speed) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: lin exp %0d got %0d, ang exp %0d got %0d",
                                 want.lin, o_linear_speed, want.ang, o_angular_speed);
                end
            end
        end
    end

    // send one request and hold it until accepted; valid stays up for the next one
    task automatic send_request(t_request r);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_mode     <= r.mode;
        i_goal_vx  <= r.gvx;  i_goal_vy  <= r.gvy;
        i_form_vx  <= r.fvx;  i_form_vy  <= r.fvy;
        i_avoid_vx <= r.avx;  i_avoid_vy <= r.avy;
        i_yaw      <= r.yaw;
        do @(negedge i_clk); while (o_stall);
        pending_cmds.push_back(velocity_command(r));
        requests_sent++;
        @(posedge i_clk);
    endtask

    // wait until every expected command has come, plus the pipeline depth
    task automatic drain;
        i_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_GOAL_W:  cfg.goal_weight      = data[15:0];
            REG_FORM_W:  cfg.formation_weight = data[15:0];
            REG_AVOID_W: cfg.avoid_weight     = data[15:0];
            REG_GAIN:    cfg.overall_gain     = data[15:0];
            REG_INV_EPS: cfg.inv_epsilon      = data[15:0];
            REG_THRESH:  cfg.norm_threshold   = data;
            REG_MAX_LIN: cfg.max_linear       = data[14:0];
            default:     cfg.max_angular      = data[14:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_request random_request();
        t_request r;
        int       pick;
        r.mode = ($urandom_range(19) == 0) ? MODE_UNUSED : 2'($urandom_range(2));
        pick = $urandom_range(9);
        // mostly realistic speeds, sometimes full range to hit saturation
        if (pick < 6) begin
            r.gvx = 16'($signed($urandom_range(16383)) - 8192);
            r.gvy = 16'($signed($urandom_range(16383)) - 8192);
            r.fvx = 16'($signed($urandom_range(16383)) - 8192);
            r.fvy = 16'($signed($urandom_range(16383)) - 8192);
            r.avx = 16'($signed($urandom_range(16383)) - 8192);
            r.avy = 16'($signed($urandom_range(16383)) - 8192);
        end else begin
            r.gvx = 16'($urandom); r.gvy = 16'($urandom);
            r.fvx = 16'($urandom); r.fvy = 16'($urandom);
            r.avx = 16'($urandom); r.avy = 16'($urandom);
        end
        r.yaw = 16'($urandom);
        return r;
    endfunction

    task automatic test_directed_extremes;
        t_request r;
        logic signed [15:0] ext[4] = '{16'sh7FFF, -16'sh8000, 16'sh0000, 16'sh1000};
        logic signed [15:0] yaws[6] = '{16'sh0000, 16'sh4000, -16'sh4000, 16'sh7FFF,
                                        -16'sh8000, 16'sh4001};
        // every mode at each extreme, including the unused code
        for (int m = 0; m < 4; m++) begin
            for (int e = 0; e < 4; e++) begin
                r.mode = 2'(m);
                r.gvx = ext[e]; r.gvy = ext[3 - e];
                r.fvx = ext[e]; r.fvy = ext[(e + 1) % 4];
                r.avx = ext[(e + 2) % 4]; r.avy = ext[e];
                r.yaw = yaws[(m + e) % 6];
                send_request(r);
            end
        end
        // headings around the quarter and half turn folds
        for (int y = 0; y < 6; y++) begin
            r.mode = MODE_FOLLOWER;
            r.gvx = '0; r.gvy = '0;
            r.fvx = 16'sh1800; r.fvy = -16'sh0800;
            r.avx = 16'sh0400; r.avy = 16'sh0400;
            r.yaw = yaws[y];
            send_request(r);
        end
        // tiny blend sits in the dead zone
        r.mode = MODE_LEADER;
        r.gvx = 16'sd3; r.gvy = -16'sd2; r.avx = '0; r.avy = 16'sd1;
        send_request(r);
        drain();
    endtask

    task automatic test_register_settings;
        // zero reciprocal, zero linear limit, zero threshold, then full scale settings
        write_reg(REG_INV_EPS, 32'd0);
        write_reg(REG_THRESH, 32'd0);
        write_reg(REG_MAX_LIN, 32'd0);
        for (int i = 0; i < 20; i++) send_request(random_request());
        drain();
        write_reg(REG_GOAL_W, 32'hFFFF);
        write_reg(REG_FORM_W, 32'hFFFF);
        write_reg(REG_AVOID_W, 32'hFFFF);
        write_reg(REG_GAIN, 32'hFFFF);
        write_reg(REG_INV_EPS, 32'hFFFF);
        write_reg(REG_MAX_LIN, 32'h7FFF);
        write_reg(REG_MAX_ANG, 32'h7FFF);
        for (int i = 0; i < 60; i++) send_request(random_request());
        drain();
        write_reg(REG_GOAL_W, 32'd0);
        write_reg(REG_FORM_W, 32'd0);
        write_reg(REG_AVOID_W, 32'd0);
        write_reg(REG_GAIN, 32'd0);
        write_reg(REG_THRESH, 32'h8000_0000);
        write_reg(REG_MAX_ANG, 32'd0);
        for (int i = 0; i < 20; i++) send_request(random_request());
        drain();
        write_reg(REG_THRESH, 32'hFFFF_FFFF);
        for (int i = 0; i < 20; i++) send_request(random_request());
        drain();
    endtask

    task automatic test_random_settings;
        for (int phase = 0; phase < 8; phase++) begin
            write_reg(REG_GOAL_W, 32'($urandom_range(65535)));
            write_reg(REG_FORM_W, 32'($urandom_range(65535)));
            write_reg(REG_AVOID_W, 32'($urandom_range(65535)));
            write_reg(REG_GAIN, 32'($urandom_range(65535)));
            write_reg(REG_INV_EPS, 32'($urandom_range(65535, 1)));
            write_reg(REG_THRESH, 32'($urandom_range(4000000)));
            write_reg(REG_MAX_LIN, 32'($urandom_range(32767)));
            write_reg(REG_MAX_ANG, 32'($urandom_range(32767)));
            // one phase runs with no idling at all
            idle_pct = (phase == 3) ? 0 : 14;
            for (int i = 0; i < 100; i++) send_request(random_request());
            drain();
        end
        idle_pct = 14;
    endtask

    task automatic test_back_pressure;
        // receiver holds off while requests keep coming, so the input stalls
        hold_len = 120;
        hold_off = 1'b1;
        for (int i = 0; i < 100; i++) send_request(random_request());
        drain();
        // reset values again, sender pauses for full drain between bursts
        write_reg(REG_GOAL_W, 32'd3277);
        write_reg(REG_FORM_W, 32'd3277);
        write_reg(REG_AVOID_W, 32'd11469);
        write_reg(REG_GAIN, 32'd30310);
        write_reg(REG_INV_EPS, 32'd2560);
        write_reg(REG_THRESH, 32'd167772);
        write_reg(REG_MAX_LIN, 32'd4096);
        write_reg(REG_MAX_ANG, 32'd8192);
        for (int i = 0; i < 30; i++) send_request(random_request());
        drain();
    endtask

    initial begin
        cfg.goal_weight      = 16'd3277;
        cfg.formation_weight = 16'd3277;
        cfg.avoid_weight     = 16'd11469;
        cfg.overall_gain     = 16'd30310;
        cfg.inv_epsilon      = 16'd2560;
        cfg.norm_threshold   = 32'd167772;
        cfg.max_linear       = 15'd4096;
        cfg.max_angular      = 15'd8192;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_extremes();
        test_register_settings();
        test_random_settings();
        test_back_pressure();
        $display("sent %0d requests, checked %0d commands over %0d cycles, %0d mismatches",
                 requests_sent, commands_seen, cycles, mismatches);
        $display("covered all modes, heading folds, dead zone, clamps and register extremes");
        if (mismatches == 0 && pending_cmds.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
